// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the collision block.
// Depends on nothing; the user supplies clock, reset and property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is high.
`define BPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/bpc_pkg.sv =====
// Package of the bitmap pair collision block: constants, codes, types, helpers.
// Depends on nothing; used by every module of the block.
`default_nettype none

package bpc_pkg;

  localparam int MAX_DIM = 64;
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 7;
  localparam int BITS_W  = 64;
  localparam int SHIFT_W = $clog2(BITS_W);
  localparam int POS_W   = 16;
  localparam int CRD_W   = 14;

  localparam logic [1:0] FUNC_WR_A  = 2'd0;
  localparam logic [1:0] FUNC_WR_B  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] REG_WIDTH_A  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_A = 2'd1;
  localparam logic [1:0] REG_WIDTH_B  = 2'd2;
  localparam logic [1:0] REG_HEIGHT_B = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
  } query_t;

  typedef struct packed {
    logic [DIM_W-1:0] wa;
    logic [DIM_W-1:0] ha;
    logic [DIM_W-1:0] wb;
    logic [DIM_W-1:0] hb;
  } dims_t;

  typedef struct packed {
    logic               empty;
    logic [ROW_W-1:0]   ra0;
    logic [ROW_W-1:0]   rb0;
    logic [DIM_W-1:0]   rows;
    logic [SHIFT_W-1:0] sa;
    logic [SHIFT_W-1:0] sb;
    logic [BITS_W-1:0]  keep;
  } setup_t;

  // (pos + 8) / 16, truncated toward zero.
  function automatic logic signed [CRD_W-1:0] q4_to_pixel(input logic signed [POS_W-1:0] pos);
    logic signed [POS_W:0] p;
    logic signed [POS_W:0] adj;
    p   = $signed({pos[POS_W-1], pos}) + 17'sd8;
    adj = p[POS_W] ? (p + 17'sd15) : p;
    q4_to_pixel = CRD_W'(adj >>> 4);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_pair_collision.sv =====
// Top level of the bitmap pair collision block: config registers, two mask
// stores, query setup and the row-walk sequencer. Depends on bpc_pkg and submodules.
//
//   channel  signals                              item
//   -------  -----------------------------------  -----------------------------
//   input    in_valid / in_stall                  func, row, row_bits, pos_*
//   output   out_valid / out_stall                collide (one per query)
//   config   cfg_we, cfg_index, cfg_data          width_a .. height_b, 7 bits
//
// After a row write the next item can follow at once.
// A query runs from its accept through ST_SETUP, ST_WALK, which reads the N
// overlapping rows (1..MAX_DIM) of both mask stores, ST_DRAIN for the registered
// read, and ST_RESULT, which loads the result register once the output is free,
// back to ST_IDLE, which takes the next item; without overlap it skips ST_WALK
// and ST_DRAIN. Reset clears the per-row valid bits; no clearing pass is needed.
// A stalled result holds in the output register while the next item is accepted.
`default_nettype none

module bitmap_pair_collision (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [bpc_pkg::DIM_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         func,
  input  wire logic [5:0]                         row,
  input  wire logic [bpc_pkg::BITS_W-1:0]         row_bits,
  input  wire logic signed [bpc_pkg::POS_W-1:0]   pos_a_x,
  input  wire logic signed [bpc_pkg::POS_W-1:0]   pos_a_y,
  input  wire logic signed [bpc_pkg::POS_W-1:0]   pos_b_x,
  input  wire logic signed [bpc_pkg::POS_W-1:0]   pos_b_y,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    collide
);

  bpc_pkg::dims_t               dims;
  bpc_pkg::query_t              qry_in, qry;
  bpc_pkg::setup_t              st;
  logic                         in_take, row_ok, we_a, we_b;
  logic [bpc_pkg::ROW_W-1:0]    rd_addr_a, rd_addr_b;
  logic [bpc_pkg::BITS_W-1:0]   rd_data_a, rd_data_b;

  // Config registers; the user must write them only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_WIDTH_A:  dims.wa <= cfg_data;
        bpc_pkg::REG_HEIGHT_A: dims.ha <= cfg_data;
        bpc_pkg::REG_WIDTH_B:  dims.wb <= cfg_data;
        bpc_pkg::REG_HEIGHT_B: dims.hb <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Row writes go straight into the store on the accept edge; drop rows past MAX_DIM.
  assign in_take = in_valid && !in_stall;
  assign row_ok  = (7'(row) < 7'(bpc_pkg::MAX_DIM));
  assign we_a    = in_take && row_ok && (func == bpc_pkg::FUNC_WR_A);
  assign we_b    = in_take && row_ok && (func == bpc_pkg::FUNC_WR_B);

  assign qry_in.ax = pos_a_x;
  assign qry_in.ay = pos_a_y;
  assign qry_in.bx = pos_b_x;
  assign qry_in.by = pos_b_y;

  bpc_mask_mem u_mem_a (
    .clk   (clk),
    .rst   (rst),
    .we    (we_a),
    .waddr (row[bpc_pkg::ROW_W-1:0]),
    .wdata (row_bits),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  bpc_mask_mem u_mem_b (
    .clk   (clk),
    .rst   (rst),
    .we    (we_b),
    .waddr (row[bpc_pkg::ROW_W-1:0]),
    .wdata (row_bits),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  bpc_setup u_setup (
    .qry  (qry),
    .dims (dims),
    .st   (st)
  );

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .qry_in    (qry_in),
    .qry       (qry),
    .st        (st),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .collide   (collide)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_mask_mem.sv =====
// One mask store: MAX_DIM rows of 64 bits, one write and one registered read port.
// Per-row valid bits make unwritten rows read as zero. Depends on bpc_pkg.
`default_nettype none

module bpc_mask_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [bpc_pkg::ROW_W-1:0]  waddr,
  input  wire logic [bpc_pkg::BITS_W-1:0] wdata,
  input  wire logic [bpc_pkg::ROW_W-1:0]  raddr,
  output logic      [bpc_pkg::BITS_W-1:0] rdata
);

  logic [bpc_pkg::BITS_W-1:0]  rows [bpc_pkg::MAX_DIM];
  logic [bpc_pkg::MAX_DIM-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      rows[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= vld[raddr] ? rows[raddr] : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_setup.sv =====
// Query setup: pixel corners, box overlap, row starts, shifts and column mask.
// Combinational; depends on bpc_pkg.
`default_nettype none

module bpc_setup (
  input  wire bpc_pkg::query_t qry,
  input  wire bpc_pkg::dims_t  dims,
  output bpc_pkg::setup_t      st
);

  logic [bpc_pkg::DIM_W-1:0]        wa, ha, wb, hb;
  logic signed [bpc_pkg::CRD_W-1:0] ax, ay, bx, by;
  logic signed [bpc_pkg::CRD_W-1:0] ax_end, ay_end, bx_end, by_end;
  logic signed [bpc_pkg::CRD_W-1:0] x0, x1, y0, y1;
  logic signed [bpc_pkg::CRD_W-1:0] span, nrows, sa, sb, ra, rb;
  logic [bpc_pkg::DIM_W-1:0]        span_n;

  always_comb begin
    wa = bpc_pkg::clamp_dim(dims.wa);
    ha = bpc_pkg::clamp_dim(dims.ha);
    wb = bpc_pkg::clamp_dim(dims.wb);
    hb = bpc_pkg::clamp_dim(dims.hb);

    ax = bpc_pkg::q4_to_pixel(qry.ax);
    ay = bpc_pkg::q4_to_pixel(qry.ay);
    bx = bpc_pkg::q4_to_pixel(qry.bx);
    by = bpc_pkg::q4_to_pixel(qry.by);

    ax_end = ax + $signed(bpc_pkg::CRD_W'(wa));
    ay_end = ay + $signed(bpc_pkg::CRD_W'(ha));
    bx_end = bx + $signed(bpc_pkg::CRD_W'(wb));
    by_end = by + $signed(bpc_pkg::CRD_W'(hb));

    x0 = (ax > bx) ? ax : bx;
    y0 = (ay > by) ? ay : by;
    x1 = (ax_end < bx_end) ? ax_end : bx_end;
    y1 = (ay_end < by_end) ? ay_end : by_end;

    span  = x1 - x0;
    nrows = y1 - y0;
    sa    = x0 - ax;
    sb    = x0 - bx;
    ra    = y0 - ay;
    rb    = y0 - by;
    span_n = span[bpc_pkg::DIM_W-1:0];

    st.empty = (wa == '0) || (ha == '0) || (wb == '0) || (hb == '0)
               || (x1 <= x0) || (y1 <= y0);
    st.ra0   = ra[bpc_pkg::ROW_W-1:0];
    st.rb0   = rb[bpc_pkg::ROW_W-1:0];
    st.rows  = nrows[bpc_pkg::DIM_W-1:0];
    st.sa    = sa[bpc_pkg::SHIFT_W-1:0];
    st.sb    = sb[bpc_pkg::SHIFT_W-1:0];
    st.keep  = (span_n >= bpc_pkg::DIM_W'(bpc_pkg::BITS_W)) ? '1 :
               ((bpc_pkg::BITS_W'(1) << span_n) - bpc_pkg::BITS_W'(1));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_ctrl.sv =====
// Query sequencer: captures a query, walks the overlapping rows through both
// mask stores one row a cycle, and holds the result register. Depends on bpc_pkg.
`default_nettype none

module bpc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 func,
  input  wire bpc_pkg::query_t            qry_in,
  output bpc_pkg::query_t                 qry,
  input  wire bpc_pkg::setup_t            st,
  output logic [bpc_pkg::ROW_W-1:0]       rd_addr_a,
  output logic [bpc_pkg::ROW_W-1:0]       rd_addr_b,
  input  wire logic [bpc_pkg::BITS_W-1:0] rd_data_a,
  input  wire logic [bpc_pkg::BITS_W-1:0] rd_data_b,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            collide
);

  bpc_pkg::state_t              state, state_next;
  logic [bpc_pkg::ROW_W-1:0]    ra, rb;
  logic [bpc_pkg::DIM_W-1:0]    rows_left;
  logic [bpc_pkg::SHIFT_W-1:0]  sa, sb;
  logic [bpc_pkg::BITS_W-1:0]   keep;
  logic                         hit, pend, row_hit, out_free, take_query;

  assign out_free   = !out_valid || !out_stall;
  assign take_query = (state == bpc_pkg::ST_IDLE) && in_valid && (func == bpc_pkg::FUNC_QUERY);
  assign row_hit    = |(((rd_data_a >> sa) & (rd_data_b >> sb)) & keep);
  assign rd_addr_a  = ra;
  assign rd_addr_b  = rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      bpc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (take_query) begin
          state_next = bpc_pkg::ST_SETUP;
        end
      end
      bpc_pkg::ST_SETUP: begin
        state_next = st.empty ? bpc_pkg::ST_RESULT : bpc_pkg::ST_WALK;
      end
      bpc_pkg::ST_WALK: begin
        if (rows_left == bpc_pkg::DIM_W'(1)) begin
          state_next = bpc_pkg::ST_DRAIN;
        end
      end
      bpc_pkg::ST_DRAIN: begin
        state_next = bpc_pkg::ST_RESULT;
      end
      bpc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = bpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Row walk datapath.
  always_ff @(posedge clk) begin
    if (take_query) begin
      qry <= qry_in;
    end
    if (state == bpc_pkg::ST_SETUP) begin
      ra        <= st.ra0;
      rb        <= st.rb0;
      rows_left <= st.rows;
      sa        <= st.sa;
      sb        <= st.sb;
      keep      <= st.keep;
      hit       <= 1'b0;
    end else begin
      if (state == bpc_pkg::ST_WALK) begin
        ra        <= ra + bpc_pkg::ROW_W'(1);
        rb        <= rb + bpc_pkg::ROW_W'(1);
        rows_left <= rows_left - bpc_pkg::DIM_W'(1);
      end
      if (pend) begin
        hit <= hit | row_hit;
      end
    end
  end

  // Read data lands in the cycle after the address was issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == bpc_pkg::ST_WALK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == bpc_pkg::ST_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == bpc_pkg::ST_RESULT) && out_free) begin
      collide <= hit;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checks of the collision block, bound to the top level.
// Depends on bpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bpc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] func,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       collide
);

  `BPC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(collide), "stalled result changed")
  `BPC_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid, "result valid right after reset")
  `BPC_ASSERT(a_query_busy, clk, rst, in_valid && !in_stall && func == bpc_pkg::FUNC_QUERY |=> in_stall, "query accepted without busy")
  `BPC_ASSERT(a_write_fast, clk, rst, in_valid && !in_stall && func != bpc_pkg::FUNC_QUERY |=> !in_stall, "non-query item stalled input")
  `BPC_ASSERT(a_result_src, clk, rst, $rose(out_valid) |-> $past(in_stall), "result appeared while idle")

endmodule

bind bitmap_pair_collision bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench of bitmap_pair_collision: a directed table followed by randomized phases.
// Each result is checked against a typed-in value or an in-bench collision predictor. Depends on bpc_pkg.

module tb_top;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  // Longest query: MAX_DIM row reads plus setup, latency and result load.
  localparam int DRAIN_CYCLES   = bpc_pkg::MAX_DIM + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 58;
  // The fourth function code has no meaning; the block must drop it.
  localparam logic [1:0] FUNC_NOP = 2'd3;

  typedef struct {
    logic [1:0]                       func;
    logic [bpc_pkg::ROW_W-1:0]        row;
    logic [bpc_pkg::BITS_W-1:0]       bits;
    logic signed [bpc_pkg::POS_W-1:0] ax;
    logic signed [bpc_pkg::POS_W-1:0] ay;
    logic signed [bpc_pkg::POS_W-1:0] bx;
    logic signed [bpc_pkg::POS_W-1:0] by;
  } pix_item_t;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

  // One row of the directed table: a register write or an item. Where the
  // answer is obvious it is typed in; otherwise the predictor supplies it.
  typedef struct {
    step_kind_t                kind;
    logic [1:0]                reg_idx;
    logic [bpc_pkg::DIM_W-1:0] reg_val;
    pix_item_t                 item;
    logic                      fixed_exp;
    logic                      fixed_val;
  } dir_step_t;

  // Every input starts at a known value.
  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             cfg_we    = 1'b0;
  logic [1:0]                       cfg_index = '0;
  logic [bpc_pkg::DIM_W-1:0]        cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic [1:0]                       func      = '0;
  logic [5:0]                       row       = '0;
  logic [bpc_pkg::BITS_W-1:0]       row_bits  = '0;
  logic signed [bpc_pkg::POS_W-1:0] pos_a_x   = '0;
  logic signed [bpc_pkg::POS_W-1:0] pos_a_y   = '0;
  logic signed [bpc_pkg::POS_W-1:0] pos_b_x   = '0;
  logic signed [bpc_pkg::POS_W-1:0] pos_b_y   = '0;
  logic                             out_stall = 1'b0;
  wire                              in_stall;
  wire                              out_valid;
  wire                              collide;

  // Shadow copy of the block: register values and both mask stores.
  logic [bpc_pkg::DIM_W-1:0]  dim_wa, dim_ha, dim_wb, dim_hb;
  logic [bpc_pkg::BITS_W-1:0] rows_a [bpc_pkg::MAX_DIM];
  logic [bpc_pkg::BITS_W-1:0] rows_b [bpc_pkg::MAX_DIM];

  logic collide_due [$];   // expected collide bits, oldest first
  logic due_bit;
  int   fail_count     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   cfg_dirty      = 1'b0;  // items went in since the last register write

  bitmap_pair_collision uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .row       (row),
    .row_bits  (row_bits),
    .pos_a_x   (pos_a_x),
    .pos_a_y   (pos_a_y),
    .pos_b_x   (pos_b_x),
    .pos_b_y   (pos_b_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .collide   (collide)
  );

  always #CLK_HALF clk = ~clk;

  // Dimensions above the store size count as the store size.
  function automatic int clip_dim(logic [bpc_pkg::DIM_W-1:0] d);
    return (int'(d) > bpc_pkg::MAX_DIM) ? bpc_pkg::MAX_DIM : int'(d);
  endfunction

  // Q4 to pixel: add one half, divide by 16, truncate toward zero.
  function automatic int q4_pixel(logic signed [bpc_pkg::POS_W-1:0] p);
    return (int'(p) + 8) / 16;
  endfunction

  // Intersect both boxes and scan the overlap row by row for a shared pixel.
  function automatic logic overlap_hit(pix_item_t it);
    int wa, ha, wb, hb, ax, ay, bx, by, x0, x1, y0, y1, span, sa, sb;
    logic [bpc_pkg::BITS_W-1:0] keep, va, vb;
    wa = clip_dim(dim_wa);
    ha = clip_dim(dim_ha);
    wb = clip_dim(dim_wb);
    hb = clip_dim(dim_hb);
    // A mask with no area never collides.
    if (wa == 0 || ha == 0 || wb == 0 || hb == 0) return 1'b0;
    ax = q4_pixel(it.ax);
    ay = q4_pixel(it.ay);
    bx = q4_pixel(it.bx);
    by = q4_pixel(it.by);
    x0 = (ax > bx) ? ax : bx;
    x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
    y0 = (ay > by) ? ay : by;
    y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
    // Boxes that only touch or lie apart share no pixel.
    if (x1 <= x0 || y1 <= y0) return 1'b0;
    span = x1 - x0;
    sa   = x0 - ax;
    sb   = x0 - bx;
    keep = (span >= bpc_pkg::BITS_W) ? '1 : ((64'd1 << span) - 64'd1);
    for (int y = y0; y < y1; y++) begin
      va = (rows_a[y - ay] >> sa) & keep;
      vb = (rows_b[y - by] >> sb) & keep;
      if ((va & vb) != '0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dir_step_t cfg_step(logic [1:0] idx, logic [bpc_pkg::DIM_W-1:0] val);
    dir_step_t s;
    s = '{kind: STEP_CFG, reg_idx: idx, reg_val: val, item: '{default: '0},
          fixed_exp: 1'b0, fixed_val: 1'b0};
    return s;
  endfunction

  function automatic dir_step_t item_step(logic [1:0] f, logic [5:0] r,
                                          logic [bpc_pkg::BITS_W-1:0] b,
                                          int ax, int ay, int bx, int by,
                                          logic fixed, logic val);
    dir_step_t s;
    s.kind      = STEP_ITEM;
    s.reg_idx   = '0;
    s.reg_val   = '0;
    s.item      = '{func: f, row: r, bits: b, ax: 16'(ax), ay: 16'(ay),
                    bx: 16'(bx), by: 16'(by)};
    s.fixed_exp = fixed;
    s.fixed_val = val;
    return s;
  endfunction

  // Write one register. Called at a falling edge; drain the block first if
  // items went in, since a query may still be walking rows.
  task automatic write_reg(logic [1:0] idx, logic [bpc_pkg::DIM_W-1:0] val);
    if (cfg_dirty) begin
      in_valid = 1'b0;
      while (collide_due.size() != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
      cfg_dirty = 1'b0;
    end
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bpc_pkg::REG_WIDTH_A:  dim_wa = val;
      bpc_pkg::REG_HEIGHT_A: dim_ha = val;
      bpc_pkg::REG_WIDTH_B:  dim_wb = val;
      bpc_pkg::REG_HEIGHT_B: dim_hb = val;
      default: ;
    endcase
  endtask

  // Present one item at a falling edge, hold it until accepted, then update
  // the shadow state. Returns at the next falling edge with valid still high.
  task automatic send_item(pix_item_t it, logic fixed_exp = 1'b0, logic fixed_val = 1'b0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func     = it.func;
    row      = it.row;
    row_bits = it.bits;
    pos_a_x  = it.ax;
    pos_a_y  = it.ay;
    pos_b_x  = it.bx;
    pos_b_y  = it.by;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    case (it.func)
      bpc_pkg::FUNC_WR_A:
        if (int'(it.row) < bpc_pkg::MAX_DIM) rows_a[it.row] = it.bits;
      bpc_pkg::FUNC_WR_B:
        if (int'(it.row) < bpc_pkg::MAX_DIM) rows_b[it.row] = it.bits;
      bpc_pkg::FUNC_QUERY:
        collide_due.push_back(fixed_exp ? fixed_val : overlap_hit(it));
      default: ;
    endcase
    cfg_dirty = 1'b1;
    @(negedge clk);
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (collide_due.size() == 0) begin
        $error("collide: result with no expectation, actual %0b", collide);
        fail_count++;
      end else begin
        due_bit = collide_due.pop_front();
        if (collide !== due_bit) begin
          $error("collide mismatch: expected %0b, actual %0b", due_bit, collide);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[bitmap_pair_collision] ERROR");
    $finish;
  end

  initial begin
    dir_step_t plan [$];
    pix_item_t it;
    int wa_c, ha_c, wb_c, hb_c, pick, lim, apix, aypix, bpix, bypix, sent;

    dim_wa = '0;
    dim_ha = '0;
    dim_wb = '0;
    dim_hb = '0;
    for (int r = 0; r < bpc_pkg::MAX_DIM; r++) begin
      rows_a[r] = '0;
      rows_b[r] = '0;
    end

    // Hold reset for the opening cycles, release it at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed table. Masks start clear and all dimensions start at zero.
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 0, 0, 1'b1, 1'b0));
    plan.push_back(cfg_step(bpc_pkg::REG_WIDTH_A, 7'd8));
    plan.push_back(cfg_step(bpc_pkg::REG_HEIGHT_A, 7'd8));
    plan.push_back(cfg_step(bpc_pkg::REG_WIDTH_B, 7'd8));
    plan.push_back(cfg_step(bpc_pkg::REG_HEIGHT_B, 7'd8));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 0, 0, 1'b1, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_WR_A, 0, '1, 0, 0, 0, 0, 1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_WR_B, 0, '1, 0, 0, 0, 0, 1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 0, 0, 1'b1, 1'b1));
    // Boxes side by side, touching at one edge.
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 128, 0, 1'b1, 1'b0));
    // Rounding just below and at the half-pixel boundary.
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 119, 0, 1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 120, 0, 1'b0, 1'b0));
    // Negative positions truncate toward zero.
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, -9, 0, 0, 0, 1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, -24, -24, 0, 0, 1'b0, 1'b0));
    // Extreme corners, far apart.
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 32767, -32768, -32768, 32767,
                             1'b1, 1'b0));
    // Set bits that lie beyond the mask width must not count.
    plan.push_back(item_step(bpc_pkg::FUNC_WR_A, 1, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0, 0,
                             1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_WR_B, 1, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0, 0,
                             1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 0, 16, 1'b0, 1'b0));
    // Unused function code: no result.
    plan.push_back(item_step(FUNC_NOP, 63, '1, -1, -1, -1, -1, 1'b0, 1'b0));
    // Oversized dimensions clamp to the store size; meet at the far corner.
    plan.push_back(cfg_step(bpc_pkg::REG_WIDTH_A, 7'd127));
    plan.push_back(cfg_step(bpc_pkg::REG_HEIGHT_A, 7'd127));
    plan.push_back(cfg_step(bpc_pkg::REG_WIDTH_B, 7'd65));
    plan.push_back(cfg_step(bpc_pkg::REG_HEIGHT_B, 7'd64));
    plan.push_back(item_step(bpc_pkg::FUNC_WR_A, 63, 64'h8000_0000_0000_0000, 0, 0, 0, 0,
                             1'b0, 1'b0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 1008, 1008, 1'b0, 1'b0));
    // One mask without area.
    plan.push_back(cfg_step(bpc_pkg::REG_WIDTH_B, 7'd0));
    plan.push_back(item_step(bpc_pkg::FUNC_QUERY, 0, '0, 0, 0, 0, 0, 1'b1, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_item(plan[i].item, plan[i].fixed_exp, plan[i].fixed_val);
    end

    // Random phases: each picks a mask setting and a pattern of idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case (ph)
        0: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd64);  write_reg(bpc_pkg::REG_HEIGHT_A, 7'd64);
          write_reg(bpc_pkg::REG_WIDTH_B, 7'd64);  write_reg(bpc_pkg::REG_HEIGHT_B, 7'd64);
        end
        1: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd127); write_reg(bpc_pkg::REG_HEIGHT_A, 7'd127);
          write_reg(bpc_pkg::REG_WIDTH_B, 7'd65);  write_reg(bpc_pkg::REG_HEIGHT_B, 7'd127);
        end
        2: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd1);   write_reg(bpc_pkg::REG_HEIGHT_A, 7'd1);
          write_reg(bpc_pkg::REG_WIDTH_B, 7'd1);   write_reg(bpc_pkg::REG_HEIGHT_B, 7'd1);
        end
        3: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd1);   write_reg(bpc_pkg::REG_HEIGHT_A, 7'd64);
          write_reg(bpc_pkg::REG_WIDTH_B, 7'd64);  write_reg(bpc_pkg::REG_HEIGHT_B, 7'd1);
        end
        4: begin
          // Mask A without area: every query must report no collision.
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd0);
          write_reg(bpc_pkg::REG_HEIGHT_A, 7'($urandom_range(1, 64)));
          write_reg(bpc_pkg::REG_WIDTH_B, 7'($urandom_range(1, 64)));
          write_reg(bpc_pkg::REG_HEIGHT_B, 7'($urandom_range(1, 64)));
        end
        5: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'd64);  write_reg(bpc_pkg::REG_HEIGHT_A, 7'd1);
          write_reg(bpc_pkg::REG_WIDTH_B, 7'd1);   write_reg(bpc_pkg::REG_HEIGHT_B, 7'd64);
        end
        default: begin
          write_reg(bpc_pkg::REG_WIDTH_A, 7'($urandom_range(1, 64)));
          write_reg(bpc_pkg::REG_HEIGHT_A, 7'($urandom_range(1, 64)));
          write_reg(bpc_pkg::REG_WIDTH_B, 7'($urandom_range(1, 64)));
          write_reg(bpc_pkg::REG_HEIGHT_B, 7'($urandom_range(1, 64)));
        end
      endcase
      wa_c = clip_dim(dim_wa);
      ha_c = clip_dim(dim_ha);
      wb_c = clip_dim(dim_wb);
      hb_c = clip_dim(dim_hb);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Once in the run, hold the sender until every result is back.
        if (ph == 6 && sent == PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          while (collide_due.size() != 0) @(negedge clk);
        end
        // Fields not used by an item still get random content.
        it.row  = 6'($urandom);
        it.bits = {$urandom, $urandom};
        it.ax   = 16'($urandom);
        it.ay   = 16'($urandom);
        it.bx   = 16'($urandom);
        it.by   = 16'($urandom);
        pick    = int'($urandom_range(0, 99));
        if (pick < 44) begin
          it.func = $urandom_range(0, 1) ? bpc_pkg::FUNC_WR_B : bpc_pkg::FUNC_WR_A;
          lim = (it.func == bpc_pkg::FUNC_WR_A) ? ha_c : hb_c;
          if (lim == 0) lim = bpc_pkg::MAX_DIM;
          // Mostly rows inside the mask, so that queries can see them.
          if ($urandom_range(0, 9) < 7) it.row = 6'($urandom_range(0, lim - 1));
          // Keep most rows sparse so that both answers stay common.
          case ($urandom_range(0, 5))
            0: it.bits = {$urandom, $urandom};
            1, 2: it.bits = {$urandom, $urandom} & {$urandom, $urandom} &
                            {$urandom, $urandom};
            3: it.bits = 64'd1 << $urandom_range(0, 63);
            4: it.bits = '0;
            default: it.bits = {$urandom, $urandom} & {$urandom, $urandom} &
                               {$urandom, $urandom} & {$urandom, $urandom};
          endcase
        end else if (pick < 90) begin
          // Place B around A so that the boxes overlap, touch or just miss.
          it.func = bpc_pkg::FUNC_QUERY;
          apix  = int'($urandom_range(0, 120)) - 60;
          aypix = int'($urandom_range(0, 120)) - 60;
          bpix  = apix + int'($urandom_range(0, wa_c + wb_c + 2)) - (wb_c + 1);
          bypix = aypix + int'($urandom_range(0, ha_c + hb_c + 2)) - (hb_c + 1);
          it.ax = 16'(apix * 16 + int'($urandom_range(0, 15)) - 8);
          it.ay = 16'(aypix * 16 + int'($urandom_range(0, 15)) - 8);
          it.bx = 16'(bpix * 16 + int'($urandom_range(0, 15)) - 8);
          it.by = 16'(bypix * 16 + int'($urandom_range(0, 15)) - 8);
        end else if (pick < 95) begin
          it.func = bpc_pkg::FUNC_QUERY;   // full-range corners, mostly far apart
        end else begin
          it.func = FUNC_NOP;
        end
        send_item(it);
        if (it.func != FUNC_NOP) sent++;
      end
    end

    // Drop valid, wait for the last results, then let the block settle.
    in_valid = 1'b0;
    while (collide_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[bitmap_pair_collision] OK");
    end else begin
      $display("[bitmap_pair_collision] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_mask_mem.sv
hw/rtl/bpc_setup.sv
hw/rtl/bpc_ctrl.sv
hw/rtl/bitmap_pair_collision.sv
hw/rtl/bpc_checker.sv
tb/sv/tb_top.sv
